// ===== hdl/sssi_pkg.sv =====
package sssi_pkg;

    localparam int COORD_W   = 32;
    localparam int TOL_W     = 16;
    localparam int BOUND_W   = COORD_W + 2;
    localparam int NUM_W     = 99;
    localparam int DEN_W     = 67;
    localparam int Q_W       = 32;
    localparam int DIV_LAT   = Q_W + 1;
    localparam int S_DATA_W  = 288;
    localparam int M_DATA_W  = 104;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;

    // bounding boxes and sign flags that travel beside the arithmetic
    typedef struct packed {
        logic signed [BOUND_W-1:0] ax_lo;
        logic signed [BOUND_W-1:0] ax_hi;
        logic signed [BOUND_W-1:0] ay_lo;
        logic signed [BOUND_W-1:0] ay_hi;
        logic signed [BOUND_W-1:0] bx_lo;
        logic signed [BOUND_W-1:0] bx_hi;
        logic signed [BOUND_W-1:0] by_lo;
        logic signed [BOUND_W-1:0] by_hi;
        logic [COORD_W-1:0]        z;
        logic                      neg_x;
        logic                      neg_y;
    } side_t;

    // divider result: quotient and whether it fits in Q_W bits
    typedef struct packed {
        logic           vld;
        logic           ok;
        logic [Q_W-1:0] q;
    } div_res_t;

    function automatic logic signed [BOUND_W-1:0] lo_bound(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic [TOL_W-1:0]          t
    );
        logic signed [COORD_W-1:0] m;
        m = (a < b) ? a : b;
        return {{2{m[COORD_W-1]}}, m} - {{(BOUND_W-TOL_W){1'b0}}, t};
    endfunction

    function automatic logic signed [BOUND_W-1:0] hi_bound(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic [TOL_W-1:0]          t
    );
        logic signed [COORD_W-1:0] m;
        m = (a < b) ? b : a;
        return {{2{m[COORD_W-1]}}, m} + {{(BOUND_W-TOL_W){1'b0}}, t};
    endfunction

endpackage

// ===== hdl/sssi_div.sv =====
module sssi_div
    import sssi_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_vld,
    input  logic [NUM_W-1:0] n_mag,
    input  logic [DEN_W-1:0] d_mag,
    output div_res_t         res
);

    logic [DEN_W:0]   r_reg   [0:Q_W];
    logic [Q_W-1:0]   nlo_reg [0:Q_W];
    logic [DEN_W-1:0] d_reg   [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic             ok_reg  [0:Q_W];
    logic             vld_reg [0:Q_W];

    // entry: quotient fits in Q_W bits only if the high part is below the divisor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
        end
        if (en) begin
            ok_reg[0]  <= n_mag[NUM_W-1:Q_W] < d_mag;
            r_reg[0]   <= {1'b0, n_mag[NUM_W-1:Q_W]};
            nlo_reg[0] <= n_mag[Q_W-1:0];
            d_reg[0]   <= d_mag;
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        logic [DEN_W:0] rs;
        logic           ge;
        always_comb begin
            rs = {r_reg[k-1][DEN_W-1:0], nlo_reg[k-1][Q_W-1]};
            ge = rs >= {1'b0, d_reg[k-1]};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            if (en) begin
                r_reg[k]   <= ge ? (rs - {1'b0, d_reg[k-1]}) : rs;
                nlo_reg[k] <= {nlo_reg[k-1][Q_W-2:0], 1'b0};
                d_reg[k]   <= d_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][Q_W-2:0], ge};
                ok_reg[k]  <= ok_reg[k-1];
            end
        end
    end

    assign res.vld = vld_reg[Q_W];
    assign res.ok  = ok_reg[Q_W];
    assign res.q   = q_reg[Q_W];

endmodule

// ===== hdl/segment_segment_intersection_unit.sv =====
// throughput: one request per cycle while no result is stalled; 6 arithmetic stages,
// a 33-stage divider (an entry stage, then one quotient bit per stage), then the
// output register
// the whole pipeline holds while a result waits on m_tready
// reset (aresetn low, synchronous) clears all valid bits and sets tolerance to 655
module segment_segment_intersection_unit
    import sssi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tolerance_we,
    input  logic [TOL_W-1:0]     tolerance_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y,
    // b_end_x, b_end_y, layer_z (32 bits each)
    input  logic [S_DATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // found (1), cross_x (32), cross_y (32), cross_z (32), zero pad (7)
    output logic [M_DATA_W-1:0]  m_tdata
);

    // tolerance register
    logic [TOL_W-1:0] tol_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (tolerance_we) begin
            tol_reg <= tolerance_wdata;
        end
    end

    // global advance: everything moves unless a result is stuck at the output
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // input field split
    logic signed [COORD_W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
    assign x1 = s_tdata[31:0];
    assign y1 = s_tdata[63:32];
    assign x2 = s_tdata[95:64];
    assign y2 = s_tdata[127:96];
    assign x3 = s_tdata[159:128];
    assign y3 = s_tdata[191:160];
    assign x4 = s_tdata[223:192];
    assign y4 = s_tdata[255:224];

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    side_t side1_reg, side2_reg, side3_reg, side4_reg, side5_reg, side6_reg;
    side_t side6_next;

    // stage 1: endpoint cross products, direction deltas, widened boxes
    logic signed [63:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [32:0] dxa1_reg, dya1_reg, dxb1_reg, dyb1_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg   <= x1 * y2;
            p2_reg   <= y1 * x2;
            p3_reg   <= x3 * y4;
            p4_reg   <= y3 * x4;
            dxa1_reg <= {x1[31], x1} - {x2[31], x2};
            dya1_reg <= {y1[31], y1} - {y2[31], y2};
            dxb1_reg <= {x3[31], x3} - {x4[31], x4};
            dyb1_reg <= {y3[31], y3} - {y4[31], y4};
            side1_reg.ax_lo <= lo_bound(x1, x2, tol_reg);
            side1_reg.ax_hi <= hi_bound(x1, x2, tol_reg);
            side1_reg.ay_lo <= lo_bound(y1, y2, tol_reg);
            side1_reg.ay_hi <= hi_bound(y1, y2, tol_reg);
            side1_reg.bx_lo <= lo_bound(x3, x4, tol_reg);
            side1_reg.bx_hi <= hi_bound(x3, x4, tol_reg);
            side1_reg.by_lo <= lo_bound(y3, y4, tol_reg);
            side1_reg.by_hi <= hi_bound(y3, y4, tol_reg);
            side1_reg.z     <= s_tdata[287:256];
            side1_reg.neg_x <= 1'b0;
            side1_reg.neg_y <= 1'b0;
        end
    end

    // stage 2: line constants da, db and denominator products
    logic signed [64:0] da2_reg, db2_reg;
    logic signed [65:0] dd1_reg, dd2_reg;
    logic signed [32:0] dxa2_reg, dya2_reg, dxb2_reg, dyb2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            da2_reg   <= {p1_reg[63], p1_reg} - {p2_reg[63], p2_reg};
            db2_reg   <= {p3_reg[63], p3_reg} - {p4_reg[63], p4_reg};
            dd1_reg   <= dxa1_reg * dyb1_reg;
            dd2_reg   <= dya1_reg * dxb1_reg;
            dxa2_reg  <= dxa1_reg;
            dya2_reg  <= dya1_reg;
            dxb2_reg  <= dxb1_reg;
            dyb2_reg  <= dyb1_reg;
            side2_reg <= side1_reg;
        end
    end

    // stage 3: denominator, numerator partial products (33x33 each)
    logic signed [66:0] den3_reg;
    logic signed [65:0] axl_reg, axh_reg, bxl_reg, bxh_reg;
    logic signed [65:0] ayl_reg, ayh_reg, byl_reg, byh_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            den3_reg  <= {dd1_reg[65], dd1_reg} - {dd2_reg[65], dd2_reg};
            axl_reg   <= $signed({1'b0, da2_reg[31:0]}) * dxb2_reg;
            axh_reg   <= $signed(da2_reg[64:32]) * dxb2_reg;
            ayl_reg   <= $signed({1'b0, da2_reg[31:0]}) * dyb2_reg;
            ayh_reg   <= $signed(da2_reg[64:32]) * dyb2_reg;
            bxl_reg   <= $signed({1'b0, db2_reg[31:0]}) * dxa2_reg;
            bxh_reg   <= $signed(db2_reg[64:32]) * dxa2_reg;
            byl_reg   <= $signed({1'b0, db2_reg[31:0]}) * dya2_reg;
            byh_reg   <= $signed(db2_reg[64:32]) * dya2_reg;
            side3_reg <= side2_reg;
        end
    end

    // stage 4: assemble the four 98-bit products
    logic [97:0] ax4_reg, bx4_reg, ay4_reg, by4_reg;
    logic [66:0] den4_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            ax4_reg   <= {axh_reg, 32'd0} + {{32{axl_reg[65]}}, axl_reg};
            bx4_reg   <= {bxh_reg, 32'd0} + {{32{bxl_reg[65]}}, bxl_reg};
            ay4_reg   <= {ayh_reg, 32'd0} + {{32{ayl_reg[65]}}, ayl_reg};
            by4_reg   <= {byh_reg, 32'd0} + {{32{byl_reg[65]}}, byl_reg};
            den4_reg  <= den3_reg;
            side4_reg <= side3_reg;
        end
    end

    // stage 5: numerators
    logic [NUM_W-1:0] xn5_reg, yn5_reg;
    logic [DEN_W-1:0] den5_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            xn5_reg   <= {ax4_reg[97], ax4_reg} - {bx4_reg[97], bx4_reg};
            yn5_reg   <= {ay4_reg[97], ay4_reg} - {by4_reg[97], by4_reg};
            den5_reg  <= den4_reg;
            side5_reg <= side4_reg;
        end
    end

    // stage 6: magnitudes and quotient signs
    always_comb begin
        side6_next       = side5_reg;
        side6_next.neg_x = xn5_reg[NUM_W-1] ^ den5_reg[DEN_W-1];
        side6_next.neg_y = yn5_reg[NUM_W-1] ^ den5_reg[DEN_W-1];
    end

    logic [NUM_W-1:0] xm6_reg, ym6_reg;
    logic [DEN_W-1:0] dm6_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            xm6_reg <= xn5_reg[NUM_W-1] ? (~xn5_reg + 1'b1) : xn5_reg;
            ym6_reg <= yn5_reg[NUM_W-1] ? (~yn5_reg + 1'b1) : yn5_reg;
            dm6_reg <= den5_reg[DEN_W-1] ? (~den5_reg + 1'b1) : den5_reg;
            side6_reg <= side6_next;
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // bit-per-stage dividers for x and y; zero divisor fails the fit test
    div_res_t div_x, div_y;
    sssi_div u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (v6_reg),
        .n_mag   (xm6_reg),
        .d_mag   (dm6_reg),
        .res     (div_x)
    );
    sssi_div u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (v6_reg),
        .n_mag   (ym6_reg),
        .d_mag   (dm6_reg),
        .res     (div_y)
    );

    // side data delay matching the divider depth
    side_t side_dly_reg [0:DIV_LAT-1];
    always_ff @(posedge aclk) begin
        if (en) begin
            side_dly_reg[0] <= side6_reg;
        end
    end
    for (genvar k = 1; k < DIV_LAT; k++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (en) begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
        end
    end

    // result: sign, signed-range check, box tests
    side_t                     sd;
    logic                      fit_x, fit_y, hit;
    logic signed [COORD_W-1:0] px, py;
    logic signed [BOUND_W-1:0] pxe, pye;
    always_comb begin
        sd    = side_dly_reg[DIV_LAT-1];
        fit_x = div_x.ok && (sd.neg_x ? (div_x.q <= 32'h8000_0000)
                                      : (div_x.q <= 32'h7FFF_FFFF));
        fit_y = div_y.ok && (sd.neg_y ? (div_y.q <= 32'h8000_0000)
                                      : (div_y.q <= 32'h7FFF_FFFF));
        px    = sd.neg_x ? (~div_x.q + 1'b1) : div_x.q;
        py    = sd.neg_y ? (~div_y.q + 1'b1) : div_y.q;
        pxe   = {{2{px[COORD_W-1]}}, px};
        pye   = {{2{py[COORD_W-1]}}, py};
        hit   = fit_x && fit_y &&
                pxe >= sd.ax_lo && pxe <= sd.ax_hi &&
                pye >= sd.ay_lo && pye <= sd.ay_hi &&
                pxe >= sd.bx_lo && pxe <= sd.bx_hi &&
                pye >= sd.by_lo && pye <= sd.by_hi;
    end

    // output register
    logic               m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_x.vld;
        end
        if (en) begin
            m_data_reg <= {7'd0, sd.z, (hit ? py : {COORD_W{1'b0}}),
                           (hit ? px : {COORD_W{1'b0}}), hit};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== hdl/sssi_chk.sv =====
module sssi_chk
    import sssi_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no hit means zero crossing point
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[64:1] == '0)
        else $error("crossing point nonzero without hit");

    // reset empties the output
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // the pipeline only holds while a result is stalled
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input blocked with free output");

endmodule

bind segment_segment_intersection_unit sssi_chk u_sssi_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import sssi_pkg::*;

    localparam int LATENCY    = 40;
    localparam int STALL_MAX  = 20000;
    localparam int N_RANDOM   = 1030;

    // one request: both segments plus the z value that rides along
    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] by1;
        logic signed [31:0] bx1;
        logic signed [31:0] by0;
        logic signed [31:0] bx0;
        logic signed [31:0] ay1;
        logic signed [31:0] ax1;
        logic signed [31:0] ay0;
        logic signed [31:0] ax0;
    } seg_pair_t;

    typedef struct {
        logic        found;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
    } crossing_t;

    // directed row: request, and whether the expected crossing is typed in
    typedef struct {
        seg_pair_t pair;
        logic      fixed;
        crossing_t want;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 tolerance_we = 1'b0;
    logic [TOL_W-1:0]     tolerance_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;

    segment_segment_intersection_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .tolerance_we    (tolerance_we),
        .tolerance_wdata (tolerance_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    crossing_t pending_crossings[$];
    logic [TOL_W-1:0] tol_shadow = TOL_RESET;
    int errors = 0;
    int n_found = 0;
    int n_results = 0;
    int idle_free = 0;    // cycles left in a stretch with no idling
    int quiet_cycles = 0;
    bit in_done = 0;

    // exact crossing of the two lines, quotients truncated toward zero
    function automatic logic div_fit(input logic signed [127:0] num,
                                     input logic signed [127:0] den,
                                     output logic signed [31:0] q);
        logic signed [127:0] quo;
        if (den == 0) return 1'b0;
        quo = num / den;
        if (quo > 128'sd2147483647 || quo < -128'sd2147483648) return 1'b0;
        q = quo[31:0];
        return 1'b1;
    endfunction

    function automatic logic in_span(input logic signed [31:0] p,
                                     input logic signed [31:0] e0,
                                     input logic signed [31:0] e1,
                                     input logic [15:0] t);
        logic signed [33:0] lo, hi, pw;
        lo = (e0 < e1) ? e0 : e1;
        hi = (e0 < e1) ? e1 : e0;
        pw = p;
        return pw >= lo - $signed({18'd0, t}) && pw <= hi + $signed({18'd0, t});
    endfunction

    function automatic crossing_t crossing_of(input seg_pair_t s, input logic [15:0] t);
        logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
        logic signed [127:0] dxa, dya, dxb, dyb, da, db, den;
        logic signed [31:0] px, py;
        crossing_t r;
        x1 = s.ax0; y1 = s.ay0; x2 = s.ax1; y2 = s.ay1;
        x3 = s.bx0; y3 = s.by0; x4 = s.bx1; y4 = s.by1;
        dxa = x1 - x2; dya = y1 - y2; dxb = x3 - x4; dyb = y3 - y4;
        da = x1 * y2 - y1 * x2;
        db = x3 * y4 - y3 * x4;
        den = dxa * dyb - dya * dxb;
        px = '0; py = '0;
        r.found = div_fit(da * dxb - dxa * db, den, px)
               && div_fit(da * dyb - dya * db, den, py);
        if (r.found)
            r.found = in_span(px, s.ax0, s.ax1, t) && in_span(py, s.ay0, s.ay1, t)
                   && in_span(px, s.bx0, s.bx1, t) && in_span(py, s.by0, s.by1, t);
        r.cx = r.found ? px : 32'd0;
        r.cy = r.found ? py : 32'd0;
        r.cz = s.z;
        return r;
    endfunction

    function automatic logic idle_now();
        if (idle_free > 0) return 1'b0;
        return $urandom_range(99) < 21;
    endfunction

    // send one request, holding tvalid until the handshake
    task automatic send_pair(input seg_pair_t s, input logic fixed, input crossing_t want);
        crossing_t exp_c;
        while (idle_now()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        exp_c = fixed ? want : crossing_of(s, tol_shadow);
        s_tdata  <= s;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_crossings = {pending_crossings, exp_c};
        @(negedge aclk);
    endtask

    // tolerance only changes with the pipeline empty
    task automatic set_tolerance(input logic [15:0] t);
        s_tvalid <= 1'b0;
        while (pending_crossings.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
        tolerance_we    <= 1'b1;
        tolerance_wdata <= t;
        @(negedge aclk);
        tolerance_we <= 1'b0;
        tol_shadow = t;
    endtask

    function automatic logic signed [31:0] rnd_coord(input int span_sel);
        case (span_sel)
            0: return $urandom;
            1: return $signed($urandom_range(65536 * 64)) - 32'sd2097152;
            default: return $signed($urandom_range(65536 * 4)) - 32'sd131072;
        endcase
    endfunction

    // mostly crossing-friendly segments: B spans across A's midpoint
    function automatic seg_pair_t rnd_pair();
        seg_pair_t s;
        int k;
        k = $urandom_range(9);
        s.ax0 = rnd_coord(k == 0 ? 0 : (k < 4 ? 1 : 2));
        s.ay0 = rnd_coord(k == 0 ? 0 : (k < 4 ? 1 : 2));
        s.ax1 = rnd_coord(k == 0 ? 0 : (k < 4 ? 1 : 2));
        s.ay1 = rnd_coord(k == 0 ? 0 : (k < 4 ? 1 : 2));
        if (k >= 2 && k <= 8) begin
            // B runs through a point near A's middle, in a random direction
            logic signed [31:0] mx, my, vx, vy;
            mx = (s.ax0 >>> 1) + (s.ax1 >>> 1);
            my = (s.ay0 >>> 1) + (s.ay1 >>> 1);
            vx = rnd_coord(2);
            vy = rnd_coord(2);
            s.bx0 = mx - vx; s.by0 = my - vy;
            s.bx1 = mx + vx; s.by1 = my + vy;
            if (k == 8) begin
                // parallel copy of A
                s.bx0 = s.ax0 + 32'sd65536; s.by0 = s.ay0;
                s.bx1 = s.ax1 + 32'sd65536; s.by1 = s.ay1;
            end
        end else begin
            s.bx0 = rnd_coord(k == 0 ? 0 : 1);
            s.by0 = rnd_coord(k == 0 ? 0 : 1);
            s.bx1 = rnd_coord(k == 0 ? 0 : 1);
            s.by1 = rnd_coord(k == 0 ? 0 : 1);
        end
        s.z = $urandom;
        return s;
    endfunction

    function automatic row_t mk(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, z,
                                input logic fixed, input logic f,
                                input int cx, input int cy);
        row_t r;
        r.pair = '{z, by1, bx1, by0, bx0, ay1, ax1, ay0, ax0};
        r.fixed = fixed;
        r.want = '{f, cx, cy, z};
        return r;
    endfunction

    localparam int ONE  = 65536;
    localparam int MAXI = 32'h7fffffff;
    localparam int MINI = 32'h80000000;

    row_t directed[$];

    function automatic void add_row(input row_t r);
        directed = {directed, r};
    endfunction

    // result checker, sampled at the rising edge
    always @(posedge aclk) begin
        crossing_t w;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (pending_crossings.size() == 0) begin
                $error("result with no request outstanding: %h", m_tdata);
                errors++;
            end else begin
                w = pending_crossings.pop_front();
                if (m_tdata[0] !== w.found) begin
                    $error("found: expected %0d actual %0d", w.found, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[32:1] !== w.cx) begin
                    $error("cross_x: expected %h actual %h", w.cx, m_tdata[32:1]);
                    errors++;
                end
                if (m_tdata[64:33] !== w.cy) begin
                    $error("cross_y: expected %h actual %h", w.cy, m_tdata[64:33]);
                    errors++;
                end
                if (m_tdata[96:65] !== w.cz) begin
                    $error("cross_z: expected %h actual %h", w.cz, m_tdata[96:65]);
                    errors++;
                end
                if (w.found) n_found++;
            end
        end
        // watchdog on cycles with no handshake on either side
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge aclk) begin
        if (quiet_cycles > STALL_MAX) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result-side backpressure, changed on the falling edge
    always @(negedge aclk) begin
        m_tready <= !idle_now();
        if (idle_free > 0) idle_free <= idle_free - 1;
    end

    initial begin
        seg_pair_t s;
        // x cross at origin; shared endpoint; parallel; collinear; degenerate point
        add_row(mk(-ONE, 0, ONE, 0, 0, -ONE, 0, ONE, 5, 1, 1, 0, 0));
        add_row(mk(0, 0, ONE, ONE, ONE, ONE, 2*ONE, 0, -1, 1, 1, ONE, ONE));
        add_row(mk(0, 0, ONE, 0, 0, ONE, ONE, ONE, MAXI, 1, 0, 0, 0));
        add_row(mk(0, 0, ONE, 0, 2*ONE, 0, 3*ONE, 0, MINI, 1, 0, 0, 0));
        add_row(mk(ONE, ONE, ONE, ONE, 0, 0, 2*ONE, 2*ONE, 0, 1, 0, 0, 0));
        // lines cross outside both boxes
        add_row(mk(0, 0, ONE, 0, 5*ONE, ONE, 5*ONE, 2*ONE, 7, 1, 0, 0, 0));
        // just inside and just outside the default slack
        add_row(mk(0, 0, ONE, 0, ONE + 655, -ONE, ONE + 655, ONE, 1, 1, 1,
                   ONE + 655, 0));
        add_row(mk(0, 0, ONE, 0, ONE + 656, -ONE, ONE + 656, ONE, 1, 1, 0, 0, 0));
        // extremes of the range
        add_row(mk(MINI, MINI, MAXI, MAXI, MINI, MAXI, MAXI, MINI, 3, 0, 0, 0, 0));
        add_row(mk(MINI, 0, MAXI, 0, 0, MINI, 0, MAXI, MINI, 1, 1, 0, 0));
        add_row(mk(MAXI, MAXI, MAXI, MINI, MINI, MAXI, MAXI, MAXI, 9, 0, 0, 0, 0));
        add_row(mk(MINI, MINI, MINI, MAXI, MINI, MINI, MAXI, MINI, 2, 0, 0, 0, 0));
        // long shallow lines, a small x cross at the origin, alternating bit patterns
        add_row(mk(0, 0, MAXI, 1, 0, 1, MAXI, 2, 4, 1, 0, 0, 0));
        add_row(mk(MINI, -1, MAXI, 1, MINI, 0, MAXI, 0, 6, 0, 0, 0, 0));
        add_row(mk(-1, -1, 1, 1, -1, 1, 1, -1, -7, 1, 1, 0, 0));
        add_row(mk(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
                   32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555, 32'h55555555,
                   32'h5a5a5a5a, 0, 0, 0, 0));

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // phase 1: reset tolerance, directed table
        foreach (directed[i])
            send_pair(directed[i].pair, directed[i].fixed, directed[i].want);

        // random phases over several tolerance settings, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_tolerance(16'd0);
                1: set_tolerance(16'hffff);
                2: set_tolerance(16'($urandom));
                3: set_tolerance(16'd1);
                default: set_tolerance(TOL_RESET);
            endcase
            if (ph == 1) idle_free = 400;
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                s = rnd_pair();
                send_pair(s, 1'b0, '{default: '0});
            end
        end
        s_tvalid <= 1'b0;

        while (pending_crossings.size() != 0) @(negedge aclk);
        repeat (LATENCY + 8) @(negedge aclk);
        $display("%0d crossings checked, %0d of them hits, over five tolerance settings",
                 n_results, n_found);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sssi_pkg.sv
hdl/sssi_div.sv
hdl/segment_segment_intersection_unit.sv
hdl/sssi_chk.sv
tb/testbench.sv
